@@ rtl/mwa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwa_pkg
// Shared widths, register codes and control types for the mirrored window
// average block.
// ----------------------------------------------------------------------------
package mwa_pkg;

  localparam int SCORE_W         = 16;
  localparam int HALF_W          = 6;
  localparam int COUNT_WIDTH     = 16;
  localparam int MAX_HALF_WINDOW = 63;
  localparam int RING_DEPTH      = 128;
  localparam int RING_AW         = $clog2(RING_DEPTH);

  localparam int RING_HALF = (RING_DEPTH - 1) / 2;
  localparam int H_CAP     = (MAX_HALF_WINDOW < RING_HALF) ? MAX_HALF_WINDOW : RING_HALF;

  localparam int DIVISOR_W = HALF_W + 1;
  localparam int SUM_W     = SCORE_W + DIVISOR_W;
  localparam int STEP_W    = $clog2(SUM_W + 1);
  localparam int JW        = COUNT_WIDTH + 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COUNT_WIDTH;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = CFG_IDX_W'(1);

  typedef struct packed {
    logic clear;
    logic acc_en;
    logic div_start;
  } mean_ctl_t;

endpackage

@@ rtl/mwa_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwa_in_if
// Score input channel: valid/ready handshake with one Q1.15 score.
// ----------------------------------------------------------------------------
interface mwa_in_if import mwa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score_in;

  modport source (output valid, output score_in, input ready);
  modport sink (input valid, input score_in, output ready);
endinterface

@@ rtl/mwa_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwa_out_if
// Result channel: valid/ready handshake with smoothed score and flags.
// ----------------------------------------------------------------------------
interface mwa_out_if import mwa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score_out;
  logic               last_out;
  logic               rejected;

  modport source (output valid, output score_out, output last_out, output rejected,
                  input ready);
  modport sink (input valid, input score_out, input last_out, input rejected,
                output ready);
endinterface

@@ rtl/mwa_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwa_ring
// Sample ring: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mwa_ring import mwa_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [RING_AW-1:0] waddr,
  input  logic [SCORE_W-1:0] wdata,
  input  logic [RING_AW-1:0] raddr,
  output logic [SCORE_W-1:0] rdata
);

  logic [SCORE_W-1:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mwa_mean.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwa_mean
// Window accumulator and restoring divider sharing one adder. Accumulates
// ring reads, then divides the sum by the window length, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module mwa_mean import mwa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  mean_ctl_t            ctl,
  input  logic [SCORE_W-1:0]   data,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 busy,
  output logic [SCORE_W-1:0]   quotient
);

  logic [SUM_W-1:0]     acc;
  logic [DIVISOR_W-1:0] rem;
  logic [STEP_W-1:0]    steps;

  logic [DIVISOR_W:0]   shifted;
  logic [SUM_W:0]       op_a;
  logic [SUM_W:0]       op_b;
  logic                 carry_in;
  logic [SUM_W:0]       total;
  logic                 neg;

  assign busy     = (steps != '0);
  assign shifted  = {rem, acc[SUM_W-1]};
  assign quotient = acc[SCORE_W-1:0];

  // shared adder: acc + data while summing, shifted - divisor while dividing
  always_comb begin
    if (busy) begin
      op_a     = (SUM_W+1)'(shifted);
      op_b     = ~((SUM_W+1)'(divisor));
      carry_in = 1'b1;
    end else begin
      op_a     = (SUM_W+1)'(acc);
      op_b     = (SUM_W+1)'(data);
      carry_in = 1'b0;
    end
    total = op_a + op_b + (SUM_W+1)'(carry_in);
    neg   = total[SUM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
    end else if (ctl.div_start) begin
      steps <= STEP_W'(SUM_W);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rem <= neg ? shifted[DIVISOR_W-1:0] : total[DIVISOR_W-1:0];
      acc <= {acc[SUM_W-2:0], ~neg};
    end else if (ctl.div_start) begin
      rem <= '0;
    end else if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= total[SUM_W-1:0];
    end
  end

endmodule

@@ rtl/mirrored_window_average.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mirrored_window_average
// Centered moving average over a stream of Q1.15 scores with mirrored edges.
//
//   port      dir  handshake            payload
//   samples   in   valid/ready          score_in
//   results   out  valid/ready          score_out, last_out, rejected
//   cfg       in   cfg_we (no stall)    cfg_index, cfg_wdata
//
// Each smoothed result passes through a start state, 2h+1 ring reads (one per
// cycle), a drain state, a divider launch, the shared divider and an output
// state. An item without a result is taken in IDLE alone, a passed-through
// item also passes through PASS; the final item of a stream produces h+1
// results back to back. The sequencer stalls only when it has a new result
// and the output register is full and not being read.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mirrored_window_average import mwa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  mwa_in_if.sink                samples,
  mwa_out_if.source             results
);

  typedef enum logic [2:0] {
    IDLE, START, SUM, DRAIN, DIVGO, DIVW, OUT, PASS
  } state_t;

  state_t                 state;
  logic [HALF_W-1:0]      half_window;
  logic [COUNT_WIDTH-1:0] column_count;
  logic [COUNT_WIDTH-1:0] items_seen;
  logic [COUNT_WIDTH-1:0] cur_i;
  logic [COUNT_WIDTH-1:0] hi_i;
  logic [SCORE_W-1:0]     x_hold;
  logic                   final_hold;
  logic signed [JW-1:0]   j;
  logic [DIVISOR_W-1:0]   left;
  logic                   rd_pend;

  logic                   out_valid;
  logic [SCORE_W-1:0]     out_score;
  logic                   out_last;
  logic                   out_rej;

  logic [HALF_W-1:0]      h_eff;
  logic [COUNT_WIDTH-1:0] count_eff;
  logic [COUNT_WIDTH-1:0] count_m1;
  logic                   accept;
  logic                   is_final;
  logic                   is_rej;
  logic                   slot_free;
  logic                   out_load;
  logic signed [JW-1:0]   count_s;
  logic signed [JW-1:0]   k;
  logic [SCORE_W-1:0]     rd_data;
  logic                   mean_busy;
  logic [SCORE_W-1:0]     mean_q;
  mean_ctl_t              ctl;

  assign h_eff     = (half_window > HALF_W'(H_CAP)) ? HALF_W'(H_CAP) : half_window;
  assign count_eff = (column_count == '0) ? COUNT_WIDTH'(1) : column_count;
  assign count_m1  = count_eff - COUNT_WIDTH'(1);
  assign accept    = samples.valid && samples.ready;
  assign is_final  = (items_seen >= count_m1);
  assign is_rej    = (COUNT_WIDTH'(half_window) > (count_eff >> 2));
  assign slot_free = !out_valid || results.ready;
  assign out_load  = slot_free && ((state == OUT) || (state == PASS));

  assign samples.ready     = (state == IDLE);
  assign results.valid     = out_valid;
  assign results.score_out = out_score;
  assign results.last_out  = out_last;
  assign results.rejected  = out_rej;

  // mirror the window index into the stream
  always_comb begin
    count_s = $signed({2'b00, count_eff});
    if (j < 0) begin
      k = -j;
    end else if (j >= count_s) begin
      k = (count_s <<< 1) - j - $signed(JW'(2));
    end else begin
      k = j;
    end
  end

  always_comb begin
    ctl.clear     = (state == START);
    ctl.acc_en    = rd_pend;
    ctl.div_start = (state == DIVGO);
  end

  mwa_ring u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (items_seen[RING_AW-1:0]),
    .wdata (samples.score_in),
    .raddr (k[RING_AW-1:0]),
    .rdata (rd_data)
  );

  mwa_mean u_mean (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .data     (rd_data),
    .divisor  ({h_eff, 1'b1}),
    .busy     (mean_busy),
    .quotient (mean_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      half_window  <= '0;
      column_count <= COUNT_WIDTH'(1);
      items_seen   <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      rd_pend <= (state == SUM);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_HALF_WINDOW:  half_window  <= cfg_wdata[HALF_W-1:0];
          CFG_COLUMN_COUNT: column_count <= cfg_wdata[COUNT_WIDTH-1:0];
          default:          half_window  <= half_window;
        endcase
        items_seen <= '0;
      end else if (accept) begin
        items_seen <= is_final ? '0 : items_seen + COUNT_WIDTH'(1);
      end

      case (state)
        IDLE: begin
          if (accept) begin
            x_hold     <= samples.score_in;
            final_hold <= is_final;
            cur_i      <= items_seen - COUNT_WIDTH'(h_eff);
            hi_i       <= is_final ? items_seen : items_seen - COUNT_WIDTH'(h_eff);
            if (is_rej) begin
              state <= PASS;
            end else if (items_seen >= COUNT_WIDTH'(h_eff)) begin
              state <= START;
            end
          end
        end
        START: begin
          j     <= $signed({2'b00, cur_i}) - $signed(JW'(h_eff));
          left  <= {h_eff, 1'b0};
          state <= SUM;
        end
        SUM: begin
          j <= j + $signed(JW'(1));
          if (left == '0) begin
            state <= DRAIN;
          end else begin
            left <= left - DIVISOR_W'(1);
          end
        end
        DRAIN: begin
          state <= DIVGO;
        end
        DIVGO: begin
          state <= DIVW;
        end
        DIVW: begin
          if (!mean_busy) begin
            state <= OUT;
          end
        end
        OUT: begin
          if (slot_free) begin
            out_score <= mean_q;
            out_last  <= (cur_i == count_m1);
            out_rej   <= 1'b0;
            if (cur_i == hi_i) begin
              state <= IDLE;
            end else begin
              cur_i <= cur_i + COUNT_WIDTH'(1);
              state <= START;
            end
          end
        end
        PASS: begin
          if (slot_free) begin
            out_score <= x_hold;
            out_last  <= final_hold;
            out_rej   <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
